FILE: rtl/lsbse_pkg.sv
// Shared types and constants for the LSB stego pixel embedder.
// No dependencies; compile first.
`default_nettype none
package lsbse_pkg;
    localparam int ADDR_W     = 14;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int SPAN_W     = 14;
    localparam int BUF_W      = 16;
    localparam int CNT_W      = 4;
    localparam int ADV_W      = 15;
    localparam int DIVD_W     = DATA_W + SPAN_W;

    localparam int DEF_MAX_WIDTH    = 64;
    localparam int DEF_MAX_HEIGHT   = 64;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam logic [7:0] HDR_KEEP  = 8'hF8;
    localparam logic [7:0] HDR_VMASK = 8'h07;
    localparam logic [7:0] FULL_MASK = 8'hFF;
    localparam logic [8:0] SCALE_ONE = 9'd256;

    typedef enum logic [2:0] {
        CMD_LOAD    = 3'd0,
        CMD_READ    = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_HEADER  = 3'd3,
        CMD_EMBED   = 3'd4,
        CMD_FLUSH   = 3'd5,
        CMD_SCATTER = 3'd6,
        CMD_NOP     = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_BPC      = 3'd0,
        CFG_CHANNELS = 3'd1,
        CFG_WIDTH    = 3'd2,
        CFG_HEIGHT   = 3'd3,
        CFG_DEBAND   = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_PUT_RD,
        ST_SA,
        ST_WA,
        ST_WB,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        OP_HEADER,
        OP_EMBED,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        logic [7:0]        read_data;
        logic [ADDR_W-1:0] write_index;
        logic [7:0]        written_value;
        logic              wrote;
        logic              overflow;
        logic              range_error;
        logic              last;
    } t_rsp;
endpackage
`default_nettype wire

FILE: rtl/lsbse_req_if.sv
// Command channel: valid/ready handshake carrying cmd, addr and data.
// Depends on lsbse_pkg.
`default_nettype none
interface lsbse_req_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  cmd;
    logic [lsbse_pkg::ADDR_W-1:0] addr;
    logic [lsbse_pkg::DATA_W-1:0] data;
    modport source (output valid, cmd, addr, data, input ready);
    modport sink   (input valid, cmd, addr, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lsbse_rsp_if.sv
// Result channel: valid/ready handshake carrying one result beat.
// Depends on lsbse_pkg.
`default_nettype none
interface lsbse_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [7:0]                   read_data;
    logic [lsbse_pkg::ADDR_W-1:0] write_index;
    logic [7:0]                   written_value;
    logic                         wrote;
    logic                         overflow;
    logic                         range_error;
    logic                         last;
    modport source (output valid, read_data, write_index, written_value, wrote,
                    overflow, range_error, last, input ready);
    modport sink   (input valid, read_data, write_index, written_value, wrote,
                    overflow, range_error, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/lsbse_div.sv
// Restoring divider, one quotient bit per cycle, for the scatter step.
// Depends on lsbse_pkg.
`default_nettype none
module lsbse_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [lsbse_pkg::DIVD_W-1:0]  i_dividend,
    input  wire logic [lsbse_pkg::DATA_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [lsbse_pkg::DIVD_W-1:0]       o_quot
);
    import lsbse_pkg::*;
    localparam int CW = $clog2(DIVD_W + 1);

    logic [DATA_W:0]   r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dsr;
    logic [CW-1:0]     r_cnt;
    logic              r_done;
    logic [DATA_W:0]   rem_sh;
    logic              take;

    assign rem_sh = {r_rem[DATA_W-1:0], r_quo[DIVD_W-1]};
    assign take   = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(DIVD_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (r_cnt != '0) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= take ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
            r_quo <= {r_quo[DIVD_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_cnt == '0) else $error("divider done while busy");
endmodule
`default_nettype wire

FILE: rtl/lsb_stego_pixel_embedder.sv
// LSB stego pixel embedder: cover image in one synchronous RAM, one command at a time.
// Load, restart and start-scatter finish in the idle state; a read passes through ST_RD.
// Each component write is a read-modify-write through ST_PUT_RD and ST_FIN; in scatter
// mode it adds two divisions on the shared divider, so an embedded byte costs up to
// 8 writes plus any stall on the result channel. A new command is taken while the last
// result beat still waits in the output register.
`default_nettype none
module lsb_stego_pixel_embedder #(
    parameter int MAX_WIDTH    = lsbse_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = lsbse_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = lsbse_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lsbse_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lsbse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lsbse_req_if.sink                              i_req,
    lsbse_rsp_if.source                            o_rsp
);
    import lsbse_pkg::*;

    localparam int MEM_SIZE = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int AW       = $clog2(MEM_SIZE);
    localparam int TOT_W    = $clog2(MEM_SIZE + 1);

    // configuration
    logic [3:0] r_bpc;
    logic [2:0] r_chan;
    logic [6:0] r_width;
    logic [6:0] r_height;
    logic       r_deband;

    // walk state
    t_state              r_state, n_state;
    t_op                 r_op;
    logic [ADDR_W-1:0]   r_pos;
    logic [BUF_W-1:0]    r_buf;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_scat_on;
    logic [DATA_W-1:0]   r_step;
    logic [DATA_W-1:0]   r_range;
    logic [SPAN_W-1:0]   r_span;
    logic [ADDR_W-1:0]   r_idx;
    logic [7:0]          r_val;
    logic [7:0]          r_vmask;
    logic [7:0]          r_keep;
    logic [2:0]          r_n;
    logic [DIVD_W-1:0]   r_qa;

    // memory
    logic [7:0] mem [MEM_SIZE];
    logic [7:0] r_mem_q;
    logic       r_rd_oob;
    logic       mem_re;
    logic [ADDR_W-1:0] rd_addr;

    // output register
    logic r_ovalid;
    t_rsp r_out;
    logic out_free;

    // effective configuration
    logic [3:0]       eff_bits;
    logic [7:0]       vmask;
    logic [TOT_W-1:0] total;
    logic [ADDR_W-1:0] pos_norm;

    always_comb begin
        int w, h, c;
        w = (r_width  == '0) ? 1 : ((int'(r_width)  > MAX_WIDTH)  ? MAX_WIDTH  : int'(r_width));
        h = (r_height == '0) ? 1 : ((int'(r_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(r_height));
        c = (r_chan   == '0) ? 1 : ((int'(r_chan)   > MAX_CHANNELS) ? MAX_CHANNELS
                                                                    : int'(r_chan));
        total = TOT_W'(w * h * c);
        eff_bits = (r_bpc == '0) ? 4'd1 : ((r_bpc > 4'd8) ? 4'd8 : r_bpc);
        vmask = 8'((9'd1 << eff_bits) - 9'd1);
        pos_norm = ((TOT_W + 1)'(r_pos) >= (TOT_W + 1)'(total)) ? '0 : r_pos;
    end

    logic accept;
    t_cmd cmd;
    assign cmd    = t_cmd'(i_req.cmd);
    assign accept = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;

    // scatter step arithmetic
    logic [DATA_W-1:0] step_nx;
    logic [DIVD_W-1:0] prod_a, prod_b;
    logic              div_start;
    logic [DIVD_W-1:0] div_dvd;
    logic              div_done;
    logic [DIVD_W-1:0] div_q;

    assign step_nx = r_step + DATA_W'(1);
    assign prod_a  = DIVD_W'(step_nx) * DIVD_W'(r_span);
    assign prod_b  = DIVD_W'(r_step) * DIVD_W'(r_span);

    lsbse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_range),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // merge and advance
    logic [7:0]        val_m, nv, pd;
    logic [16:0]       dprod;
    logic [ADV_W-1:0]  adv;
    logic [ADV_W:0]    newpos;
    logic              ovf, rerr;
    logic [CNT_W-1:0]  cnt_left;
    logic              more;

    always_comb begin
        val_m = r_val & r_vmask;
        dprod = 17'(r_mem_q) * 17'(SCALE_ONE - {1'b0, r_vmask});
        pd    = dprod[15:8];
        nv    = r_deband ? (pd + ((val_m - pd) & r_vmask)) : ((r_mem_q & r_keep) | val_m);
        rerr  = 1'b0;
        adv   = ADV_W'(1);
        if (r_scat_on) begin
            if (r_range == '0) begin
                rerr = 1'b1;
            end else begin
                rerr = step_nx > r_range;
                adv  = (r_qa >= div_q) ? ADV_W'(r_qa - div_q) : '0;
            end
        end
        newpos   = (ADV_W + 1)'(r_idx) + (ADV_W + 1)'(adv);
        ovf      = (TOT_W + ADV_W + 1)'(newpos) >= (TOT_W + ADV_W + 1)'(total);
        cnt_left = r_cnt - eff_bits;
        more     = (r_op == OP_EMBED) && (cnt_left >= eff_bits) && (r_n != 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        mem_re      = 1'b0;
        rd_addr     = pos_norm;
        div_start   = 1'b0;
        div_dvd     = prod_a;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                rd_addr     = i_req.addr;
                if (i_req.valid) begin
                    unique case (cmd)
                        CMD_READ: begin
                            mem_re  = 1'b1;
                            n_state = ST_RD;
                        end
                        CMD_HEADER: n_state = ST_PUT_RD;
                        CMD_EMBED: begin
                            if (r_cnt + CNT_W'(8) >= eff_bits) n_state = ST_PUT_RD;
                        end
                        CMD_FLUSH: begin
                            if (r_cnt != '0) n_state = ST_PUT_RD;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_PUT_RD: begin
                mem_re  = 1'b1;
                n_state = (r_scat_on && r_range != '0) ? ST_SA : ST_FIN;
            end
            ST_SA: begin
                div_start = 1'b1;
                n_state   = ST_WA;
            end
            ST_WA: begin
                div_dvd = prod_b;
                if (div_done) begin
                    div_start = 1'b1;
                    n_state   = ST_WB;
                end
            end
            ST_WB: begin
                if (div_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) n_state = more ? ST_PUT_RD : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept && cmd == CMD_LOAD && int'(i_req.addr) < MEM_SIZE)
            mem[i_req.addr[AW-1:0]] <= i_req.data[7:0];
        else if (r_state == ST_FIN && out_free)
            mem[r_idx[AW-1:0]] <= nv;
        if (mem_re) begin
            r_mem_q  <= mem[rd_addr[AW-1:0]];
            r_rd_oob <= int'(rd_addr) >= MEM_SIZE;
        end
    end

    // capture of the first quotient and per-write operands
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WA && div_done) r_qa <= div_q;
        if (r_state == ST_PUT_RD) r_idx <= pos_norm;
        if (r_state == ST_IDLE && accept) begin
            r_n <= '0;
            if (cmd == CMD_HEADER) begin
                r_op    <= OP_HEADER;
                r_val   <= {5'd0, i_req.data[2:0]};
                r_vmask <= HDR_VMASK;
                r_keep  <= HDR_KEEP;
            end else begin
                r_op    <= (cmd == CMD_EMBED) ? OP_EMBED : OP_FLUSH;
                r_val   <= (cmd == CMD_EMBED)
                           ? 8'((r_buf | (BUF_W'(i_req.data[7:0]) << r_cnt)))
                           : r_buf[7:0];
                r_vmask <= vmask;
                r_keep  <= FULL_MASK ^ vmask;
            end
        end else if (r_state == ST_FIN && out_free && more) begin
            r_n   <= r_n + 3'd1;
            r_val <= 8'(r_buf >> eff_bits);
        end
    end

    // walk state, buffer and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpc     <= 4'd1;
            r_chan    <= 3'd4;
            r_width   <= 7'd64;
            r_height  <= 7'd64;
            r_deband  <= 1'b0;
            r_pos     <= '0;
            r_buf     <= '0;
            r_cnt     <= '0;
            r_scat_on <= 1'b0;
            r_step    <= '0;
            r_range   <= '0;
            r_span    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BPC: begin
                        r_bpc <= i_cfg_data[3:0];
                        r_buf <= '0;
                        r_cnt <= '0;
                    end
                    CFG_CHANNELS: r_chan   <= i_cfg_data[2:0];
                    CFG_WIDTH:    r_width  <= i_cfg_data;
                    CFG_HEIGHT:   r_height <= i_cfg_data;
                    CFG_DEBAND:   r_deband <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == ST_IDLE && accept) begin
                case (cmd)
                    CMD_RESTART: begin
                        r_pos     <= '0;
                        r_buf     <= '0;
                        r_cnt     <= '0;
                        r_scat_on <= 1'b0;
                        r_step    <= '0;
                        r_range   <= '0;
                        r_span    <= '0;
                    end
                    CMD_EMBED: begin
                        r_buf <= r_buf | (BUF_W'(i_req.data[7:0]) << r_cnt);
                        r_cnt <= r_cnt + CNT_W'(8);
                    end
                    CMD_SCATTER: begin
                        r_range   <= i_req.data;
                        r_step    <= '0;
                        r_span    <= SPAN_W'(total - TOT_W'(pos_norm) - TOT_W'(1));
                        r_scat_on <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (r_state == ST_FIN && out_free) begin
                r_pos <= ovf ? '0 : ADDR_W'(newpos);
                if (r_scat_on) r_step <= step_nx;
                if (r_op == OP_EMBED) begin
                    r_buf <= r_buf >> eff_bits;
                    r_cnt <= cnt_left;
                end else if (r_op == OP_FLUSH) begin
                    r_buf <= '0;
                    r_cnt <= '0;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_RD && out_free) begin
            r_ovalid <= 1'b1;
        end else if (r_state == ST_FIN && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD && out_free) begin
            r_out <= '{read_data: r_rd_oob ? 8'd0 : r_mem_q, write_index: '0,
                       written_value: 8'd0, wrote: 1'b0, overflow: 1'b0,
                       range_error: 1'b0, last: 1'b1};
        end else if (r_state == ST_FIN && out_free) begin
            r_out <= '{read_data: 8'd0, write_index: r_idx, written_value: nv,
                       wrote: 1'b1, overflow: ovf, range_error: rerr, last: !more};
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.read_data     = r_out.read_data;
    assign o_rsp.write_index   = r_out.write_index;
    assign o_rsp.written_value = r_out.written_value;
    assign o_rsp.wrote         = r_out.wrote;
    assign o_rsp.overflow      = r_out.overflow;
    assign o_rsp.range_error   = r_out.range_error;
    assign o_rsp.last          = r_out.last;

    a_write_beat_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.wrote |-> r_out.read_data == 8'd0)
        else $error("write beat carries read data");
    a_write_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN |-> (TOT_W + 1)'(r_idx) < (TOT_W + 1)'(total))
        else $error("component write outside image");
    a_pos_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN && out_free && !ovf |=> r_pos == $past(ADDR_W'(newpos)))
        else $error("position not advanced after write");
endmodule
`default_nettype wire
